// ===== sv/eprt_pkg.sv =====
// shared types and constants of the echo pulse range timer
package eprt_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int DIST_W      = 24;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_ENABLED = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PULSE_TICKS    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SCALE_Q16      = 3'd4;

	// register reset values
	localparam logic        RST_SENSOR_ENABLED = 1'b0;
	localparam logic [7:0]  RST_SETTLE_TICKS   = 8'd2;
	localparam logic [7:0]  RST_PULSE_TICKS    = 8'd20;
	localparam logic [15:0] RST_TIMEOUT_TICKS  = 16'd20000;
	localparam logic [15:0] RST_SCALE_Q16      = 16'd1124;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_RISE   = 2'd1;
	localparam logic [1:0] ST_STUCK     = 2'd2;
	localparam logic [1:0] ST_NOT_READY = 2'd3;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_SETTLE = 5'b00010,
		PH_PULSE  = 5'b00100,
		PH_WAIT   = 5'b01000,
		PH_MEAS   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic        sensor_enabled;
		logic [7:0]  settle_ticks;
		logic [7:0]  pulse_ticks;
		logic [15:0] timeout_ticks;
		logic [15:0] scale_q16;
	} cfg_t;

	typedef struct packed {
		logic              trigger_out;
		logic              busy_res;
		logic              done_res;
		logic [1:0]        status;
		logic [DIST_W-1:0] distance_q8;
	} result_t;

endpackage

// ===== sv/eprt_if.sv =====
// handshake channels for tick beats and result beats
interface eprt_item_if;
	logic valid;
	logic ready;
	logic start_req;
	logic echo_level;

	modport source (output valid, output start_req, output echo_level, input ready);
	modport sink (input valid, input start_req, input echo_level, output ready);
endinterface

interface eprt_result_if;
	logic        valid;
	logic        ready;
	logic        trigger_out;
	logic        busy_res;
	logic        done_res;
	logic [1:0]  status;
	logic [23:0] distance_q8;

	modport source (output valid, output trigger_out, output busy_res, output done_res,
		output status, output distance_q8, input ready);
	modport sink (input valid, input trigger_out, input busy_res, input done_res,
		input status, input distance_q8, output ready);
endinterface

// ===== sv/eprt_step.sv =====
// measurement sequencer: per-tick phase update and result computation
module eprt_step #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              start_req,
	input  logic              echo_level,
	input  eprt_pkg::cfg_t    cfg,
	output eprt_pkg::result_t res
);
	import eprt_pkg::*;

	localparam int CW = COUNT_WIDTH;
	localparam int TW = (CW > 16) ? CW : 16;
	localparam int PW = CW + 16;

	phase_t          phase_q;
	logic [CW-1:0]   phase_count_q;
	logic [CW-1:0]   echo_duration_q;

	phase_t          ph;
	logic [CW-1:0]   cnt;
	logic [CW-1:0]   cnt_inc;
	logic [CW-1:0]   dur;
	logic            fin;
	result_t         r;

	logic [15:0]     tmo_raw;
	logic [TW-1:0]   tmo_ext;
	logic [TW-1:0]   tmo_cap;
	logic [CW-1:0]   tmo;
	logic [7:0]      pulse_len;
	logic [PW-1:0]   prod;
	logic [PW-1:0]   prod_sh;
	logic [DIST_W-1:0] dist_sat;

	// effective timeout: zero acts as one, clamp to counter range
	assign tmo_raw   = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
	assign tmo_ext   = TW'(tmo_raw);
	assign tmo_cap   = (tmo_ext > TW'({CW{1'b1}})) ? TW'({CW{1'b1}}) : tmo_ext;
	assign tmo       = tmo_cap[CW-1:0];
	assign pulse_len = (cfg.pulse_ticks == 8'd0) ? 8'd1 : cfg.pulse_ticks;

	// distance only ever computed on the stored duration
	assign prod     = PW'(echo_duration_q) * PW'(cfg.scale_q16);
	assign prod_sh  = prod >> 8;
	assign dist_sat = (prod_sh > PW'(DIST_MAX)) ? DIST_MAX : prod_sh[DIST_W-1:0];

	always_comb begin
		ph      = phase_q;
		cnt     = phase_count_q;
		dur     = echo_duration_q;
		cnt_inc = '0;
		fin     = 1'b0;
		r       = '0;
		r.status = ST_OK;

		if (ph == PH_IDLE) begin
			if (!start_req) begin
				fin = 1'b1;
			end else if (!cfg.sensor_enabled) begin
				r.done_res = 1'b1;
				r.status   = ST_NOT_READY;
				fin        = 1'b1;
			end else begin
				ph  = PH_SETTLE;
				cnt = '0;
			end
		end

		if (!fin && ph == PH_SETTLE) begin
			if (cnt < CW'(cfg.settle_ticks)) begin
				cnt        = cnt + 1'b1;
				r.busy_res = 1'b1;
				fin        = 1'b1;
			end else begin
				ph  = PH_PULSE;
				cnt = '0;
			end
		end

		if (!fin && ph == PH_PULSE) begin
			if (cnt < CW'(pulse_len)) begin
				cnt           = cnt + 1'b1;
				r.trigger_out = 1'b1;
				r.busy_res    = 1'b1;
				fin           = 1'b1;
			end else begin
				ph  = PH_WAIT;
				cnt = '0;
			end
		end

		if (!fin && ph == PH_WAIT) begin
			if (!echo_level) begin
				cnt_inc = cnt + 1'b1;
				if (cnt_inc >= tmo) begin
					ph         = PH_IDLE;
					cnt        = '0;
					r.done_res = 1'b1;
					r.status   = ST_NO_RISE;
				end else begin
					cnt        = cnt_inc;
					r.busy_res = 1'b1;
				end
				fin = 1'b1;
			end else begin
				ph  = PH_MEAS;
				cnt = '0;
				dur = '0;
			end
		end

		if (!fin && ph == PH_MEAS) begin
			if (echo_level) begin
				dur = dur + 1'b1;
				if (dur >= tmo) begin
					ph         = PH_IDLE;
					r.done_res = 1'b1;
					r.status   = ST_STUCK;
				end else begin
					r.busy_res = 1'b1;
				end
			end else begin
				ph            = PH_IDLE;
				cnt           = '0;
				r.done_res    = 1'b1;
				r.distance_q8 = dist_sat;
			end
		end
	end

	assign res = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			phase_count_q   <= '0;
			echo_duration_q <= '0;
		end else if (step) begin
			phase_q         <= ph;
			phase_count_q   <= cnt;
			echo_duration_q <= dur;
		end
	end

endmodule

// ===== sv/eprt_outreg.sv =====
// result register stage driving the result channel
module eprt_outreg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  eprt_pkg::result_t res,
	output logic              can_load,
	eprt_result_if.source     result
);
	import eprt_pkg::*;

	logic    valid_s2;
	result_t res_s2;

	assign can_load = !valid_s2 || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_load) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_s2 <= res;
		end
	end

	assign result.valid       = valid_s2;
	assign result.trigger_out = res_s2.trigger_out;
	assign result.busy_res    = res_s2.busy_res;
	assign result.done_res    = res_s2.done_res;
	assign result.status      = res_s2.status;
	assign result.distance_q8 = res_s2.distance_q8;

endmodule

// ===== sv/echo_pulse_range_timer.sv =====
// Ultrasonic echo ranging timer. Each beat on the item channel is one microsecond tick
// carrying a start request and the sampled echo level; each tick yields exactly one
// result beat with the trigger pin level, busy, a one-tick done flag, a status and the
// distance in 1/256 cm. The block takes one tick per clock cycle while the result channel
// does not stall. The tick sits in an input register; the phase sequencer and the single
// duration-by-scale multiply form the path into the result register, and the phase state
// advances as the tick moves into it. Backpressure on the result channel holds the input
// register and then the item channel. Configuration is written through cfg_we / cfg_index /
// cfg_data; the user must do so only while no measurement runs: the block does not check.
module echo_pulse_range_timer #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [eprt_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [eprt_pkg::CFG_DATA_W-1:0]     cfg_data,
	eprt_item_if.sink                           item,
	eprt_result_if.source                       result
);
	import eprt_pkg::*;

	cfg_t    cfg_q;
	logic    valid_s1;
	logic    start_s1;
	logic    echo_s1;
	logic    can_load;
	logic    advance;
	result_t step_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_enabled <= RST_SENSOR_ENABLED;
			cfg_q.settle_ticks   <= RST_SETTLE_TICKS;
			cfg_q.pulse_ticks    <= RST_PULSE_TICKS;
			cfg_q.timeout_ticks  <= RST_TIMEOUT_TICKS;
			cfg_q.scale_q16      <= RST_SCALE_Q16;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SENSOR_ENABLED: cfg_q.sensor_enabled <= cfg_data[0];
				REG_SETTLE_TICKS:   cfg_q.settle_ticks   <= cfg_data[7:0];
				REG_PULSE_TICKS:    cfg_q.pulse_ticks    <= cfg_data[7:0];
				REG_TIMEOUT_TICKS:  cfg_q.timeout_ticks  <= cfg_data;
				REG_SCALE_Q16:      cfg_q.scale_q16      <= cfg_data;
				default: ;
			endcase
		end
	end

	// tick leaves the input register when the result register can take it
	assign advance    = valid_s1 && can_load;
	assign item.ready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			start_s1 <= item.start_req;
			echo_s1  <= item.echo_level;
		end
	end

	eprt_step #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.start_req  (start_s1),
		.echo_level (echo_s1),
		.cfg        (cfg_q),
		.res        (step_res)
	);

	eprt_outreg u_outreg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (step_res),
		.can_load (can_load),
		.result   (result)
	);

endmodule

// ===== sv/eprt_checker.sv =====
// port-level checks for the echo pulse range timer, bound to the top level
module eprt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        trigger_out,
	input logic        busy_res,
	input logic        done_res,
	input logic [1:0]  status,
	input logic [23:0] distance_q8
);
	import eprt_pkg::*;

	logic beat;
	assign beat = out_valid && out_ready;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(trigger_out) && $stable(busy_res)
			&& $stable(done_res) && $stable(status) && $stable(distance_q8))
		else $error("result beat changed while stalled");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		beat && done_res |-> !busy_res && !trigger_out)
		else $error("done beat still busy or triggering");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		beat && status != ST_OK |-> done_res && distance_q8 == '0)
		else $error("error status without done or with distance");

	a_trigger_busy: assert property (@(posedge clk) disable iff (!arst_n)
		beat && (trigger_out || !done_res) |-> status == ST_OK && distance_q8 == '0
			&& (!trigger_out || busy_res))
		else $error("trigger or running beat carries status or distance");

endmodule

bind echo_pulse_range_timer eprt_checker u_eprt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.trigger_out (result.trigger_out),
	.busy_res    (result.busy_res),
	.done_res    (result.done_res),
	.status      (result.status),
	.distance_q8 (result.distance_q8)
);

// ===== tb/sv/echo_pulse_range_timer_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the echo pulse range timer: tick beats in, result beats checked
module echo_pulse_range_timer_test;
	import eprt_pkg::*;

	localparam int COUNT_W     = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES      = 9;
	localparam int PHASE_TICKS = 20;
	localparam int MAX_LINES   = 100;

	// predicted ranging state and the queue of result beats still owed by the block
	class range_scoreboard;
		localparam longint unsigned CNT_MAX = (64'd1 << COUNT_W) - 64'd1;

		cfg_t              regs;
		phase_t            phase;
		longint unsigned   phase_count;
		longint unsigned   echo_ticks;
		result_t           expected_q[$];
		int unsigned       errors;

		function new();
			regs.sensor_enabled = RST_SENSOR_ENABLED;
			regs.settle_ticks   = RST_SETTLE_TICKS;
			regs.pulse_ticks    = RST_PULSE_TICKS;
			regs.timeout_ticks  = RST_TIMEOUT_TICKS;
			regs.scale_q16      = RST_SCALE_Q16;
			phase       = PH_IDLE;
			phase_count = 0;
			echo_ticks  = 0;
			errors      = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SENSOR_ENABLED: regs.sensor_enabled = data[0];
				REG_SETTLE_TICKS:   regs.settle_ticks   = data[7:0];
				REG_PULSE_TICKS:    regs.pulse_ticks    = data[7:0];
				REG_TIMEOUT_TICKS:  regs.timeout_ticks  = data;
				REG_SCALE_Q16:      regs.scale_q16      = data;
				default: ;
			endcase
		endfunction

		function result_t range_tick(bit start, bit echo);
			result_t         r;
			longint unsigned pulse_len;
			longint unsigned tmo;
			longint unsigned dist_raw;
			r = '0;
			pulse_len = (regs.pulse_ticks == 0) ? 1 : regs.pulse_ticks;
			tmo = (regs.timeout_ticks == 0) ? 1 : regs.timeout_ticks;
			if (tmo > CNT_MAX)
				tmo = CNT_MAX;
			if (phase == PH_IDLE) begin
				if (!start)
					return r;
				if (!regs.sensor_enabled) begin
					r.done_res = 1'b1;
					r.status   = ST_NOT_READY;
					return r;
				end
				phase = PH_SETTLE;
				phase_count = 0;
			end
			if (phase == PH_SETTLE) begin
				if (phase_count < regs.settle_ticks) begin
					phase_count++;
					r.busy_res = 1'b1;
					return r;
				end
				phase = PH_PULSE;
				phase_count = 0;
			end
			if (phase == PH_PULSE) begin
				if (phase_count < pulse_len) begin
					phase_count++;
					r.trigger_out = 1'b1;
					r.busy_res    = 1'b1;
					return r;
				end
				phase = PH_WAIT;
				phase_count = 0;
			end
			if (phase == PH_WAIT) begin
				if (!echo) begin
					phase_count++;
					if (phase_count >= tmo) begin
						phase = PH_IDLE;
						phase_count = 0;
						r.done_res = 1'b1;
						r.status   = ST_NO_RISE;
					end else begin
						r.busy_res = 1'b1;
					end
					return r;
				end
				phase = PH_MEAS;
				phase_count = 0;
				echo_ticks = 0;
			end
			// measuring: the first high sample counts as one tick
			if (echo) begin
				echo_ticks = (echo_ticks + 1) & CNT_MAX;
				if (echo_ticks >= tmo) begin
					phase = PH_IDLE;
					r.done_res = 1'b1;
					r.status   = ST_STUCK;
				end else begin
					r.busy_res = 1'b1;
				end
				return r;
			end
			dist_raw = (echo_ticks * regs.scale_q16) >> 8;
			r.distance_q8 = (dist_raw > DIST_MAX) ? DIST_MAX : dist_raw[DIST_W-1:0];
			r.done_res = 1'b1;
			phase = PH_IDLE;
			phase_count = 0;
			return r;
		endfunction

		function void note_tick(bit start, bit echo);
			expected_q.push_back(range_tick(start, echo));
		endfunction

		task report(string msg);
			if (errors < MAX_LINES)
				$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			want = expected_q.pop_front();
			if (got.trigger_out !== want.trigger_out)
				report($sformatf("trigger_out %b, want %b", got.trigger_out, want.trigger_out));
			if (got.busy_res !== want.busy_res)
				report($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
			if (got.done_res !== want.done_res)
				report($sformatf("done_res %b, want %b", got.done_res, want.done_res));
			if (got.status !== want.status)
				report($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.distance_q8 !== want.distance_q8)
				report($sformatf("distance_q8 %0d, want %0d", got.distance_q8, want.distance_q8));
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	eprt_item_if   item_ch();
	eprt_result_if result_ch();

	echo_pulse_range_timer #(
		.COUNT_WIDTH(COUNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item_ch),
		.result(result_ch)
	);

	range_scoreboard sb;
	bit              steady;
	bit              hold_request;
	int unsigned     ticks_sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("simulation failed");
		$finish;
	end

	function automatic bit coin();
		return bit'($urandom_range(1));
	endfunction

	function automatic int unsigned timeout_of(cfg_t c);
		return (c.timeout_ticks == 0) ? 1 : c.timeout_ticks;
	endfunction

	function automatic cfg_t make_cfg(logic en, logic [7:0] settle, logic [7:0] pulse,
		logic [15:0] timeout, logic [15:0] scale);
		cfg_t c;
		c.sensor_enabled = en;
		c.settle_ticks   = settle;
		c.pulse_ticks    = pulse;
		c.timeout_ticks  = timeout;
		c.scale_q16      = scale;
		return c;
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.sensor_enabled = ($urandom_range(9) != 0);
		c.settle_ticks   = 8'(($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(4));
		c.pulse_ticks    = 8'(($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(4));
		c.timeout_ticks  = 16'(($urandom_range(4) == 0) ? $urandom_range(100)
			: $urandom_range(40));
		c.scale_q16      = 16'($urandom);
		return c;
	endfunction

	task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
	endtask

	task automatic apply_config(cfg_t c);
		put_reg(REG_SENSOR_ENABLED, CFG_DATA_W'(c.sensor_enabled));
		put_reg(REG_SETTLE_TICKS, CFG_DATA_W'(c.settle_ticks));
		put_reg(REG_PULSE_TICKS, CFG_DATA_W'(c.pulse_ticks));
		put_reg(REG_TIMEOUT_TICKS, c.timeout_ticks);
		put_reg(REG_SCALE_Q16, c.scale_q16);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// offer one tick beat and return on the edge that takes it
	task automatic send_tick(bit start, bit echo);
		if (!steady)
			while ($urandom_range(99) < 11) begin
				item_ch.valid <= 1'b0;
				@(posedge clk);
			end
		item_ch.valid      <= 1'b1;
		item_ch.start_req  <= start;
		item_ch.echo_level <= echo;
		do
			@(posedge clk);
		while (!item_ch.ready);
		sb.note_tick(start, echo);
		ticks_sent++;
	endtask

	// start, ride out settle and pulse, then echo low and high for the given tick counts
	task automatic measure(int unsigned low, int unsigned high);
		int unsigned lead;
		send_tick(1'b1, coin());
		if (sb.phase == PH_IDLE)
			return;
		lead = sb.regs.settle_ticks + ((sb.regs.pulse_ticks == 0) ? 1 : sb.regs.pulse_ticks) - 1;
		repeat (lead)
			send_tick(coin(), coin());
		for (int i = 0; i < low && sb.phase != PH_IDLE; i++)
			send_tick(coin(), 1'b0);
		for (int i = 0; i < high && sb.phase != PH_IDLE; i++)
			send_tick(coin(), 1'b1);
		if (sb.phase == PH_MEAS)
			send_tick(coin(), 1'b0);
	endtask

	task automatic finish_run();
		while (sb.phase != PH_IDLE)
			send_tick(1'b0, 1'b0);
	endtask

	// stop offering and let every owed result beat drain
	task automatic quiesce();
		item_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result({result_ch.trigger_out, result_ch.busy_res, result_ch.done_res,
				result_ch.status, result_ch.distance_q8});
	end

	initial begin
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				result_ch.ready <= 1'b0;
				for (int i = 0; i < HOLD_CYCLES; i++)
					@(posedge clk);
			end else if (steady) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= 11);
			end
		end
	end

	initial begin
		cfg_t        phase_cfg;
		int unsigned budget;
		int unsigned tmo;
		int unsigned pick;
		sb = new();
		steady       = 1'b0;
		hold_request = 1'b0;
		ticks_sent   = 0;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= '0;
		cfg_data           <= '0;
		item_ch.valid      <= 1'b0;
		item_ch.start_req  <= 1'b0;
		item_ch.echo_level <= 1'b0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sensor still disabled after reset: starts end at once
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b0);
		quiesce();

		// zero settle, zero pulse and zero timeout, largest scale
		apply_config(make_cfg(1'b1, 8'd0, 8'd0, 16'd0, 16'hFFFF));
		measure(1, 0);
		measure(0, 1);
		quiesce();

		// longest settle and pulse, zero scale gives zero distance
		apply_config(make_cfg(1'b1, 8'd255, 8'd255, 16'd3, 16'd0));
		measure(1, 2);
		quiesce();

		// widest timeout and largest scale
		apply_config(make_cfg(1'b1, 8'd1, 8'd1, 16'hFFFF, 16'hFFFF));
		measure(3, 100);
		quiesce();

		apply_config(make_cfg(1'b1, RST_SETTLE_TICKS, RST_PULSE_TICKS, RST_TIMEOUT_TICKS,
			RST_SCALE_Q16));
		measure(5, 60);
		quiesce();

		for (int p = 0; p < PHASES; p++) begin
			phase_cfg = random_cfg();
			apply_config(phase_cfg);
			tmo = timeout_of(phase_cfg);
			steady = (p == 2);
			if (p == 5)
				hold_request = 1'b1;
			budget = ticks_sent + PHASE_TICKS;
			while (ticks_sent < budget) begin
				pick = $urandom_range(99);
				if (pick < 60)
					measure($urandom_range(tmo - 1), (tmo > 1) ? $urandom_range(1, tmo - 1) : 1);
				else if (pick < 70)
					measure(tmo, 0);
				else if (pick < 80)
					measure($urandom_range(tmo - 1), tmo);
				else if (pick < 90) begin
					// cut-off run: start and a few random beats
					send_tick(1'b1, coin());
					repeat ($urandom_range(6))
						send_tick(coin(), coin());
				end else begin
					repeat ($urandom_range(1, 5))
						send_tick(1'b0, coin());
				end
			end
			finish_run();
			quiesce();
		end
		steady = 1'b0;
		repeat (8)
			@(posedge clk);

		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/eprt_pkg.sv
sv/eprt_if.sv
sv/eprt_step.sv
sv/eprt_outreg.sv
sv/echo_pulse_range_timer.sv
sv/eprt_checker.sv
tb/sv/echo_pulse_range_timer_test.sv
